// ===== hdl/wsht_pkg.sv =====
// ----------------------------------------------------------------------------
// wsht_pkg: shared constants and types for the window stack hit test block
// Widths, register indexes, request kinds and status codes.
// ----------------------------------------------------------------------------
package wsht_pkg;

    localparam int MAX_WINDOWS = 16;
    localparam int COORD_BITS  = 12;
    localparam int IDX_BITS    = $clog2(MAX_WINDOWS);
    localparam int CNT_BITS    = $clog2(MAX_WINDOWS + 1);
    localparam int CLOSE_OFFSET = 21;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [7:0]            t_handle;

    typedef struct packed {
        t_handle handle;
        t_coord  left;
        t_coord  top;
        t_coord  width;
        t_coord  height;
    } t_slot;

    localparam logic [1:0] REG_SCREEN_W = 2'd0;
    localparam logic [1:0] REG_SCREEN_H = 2'd1;
    localparam logic [1:0] REG_TITLE_H  = 2'd2;
    localparam logic [1:0] REG_CLOSE_W  = 2'd3;

    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_REMOVE = 3'd1;
    localparam logic [2:0] KIND_RAISE  = 3'd2;
    localparam logic [2:0] KIND_MOVE   = 3'd3;
    localparam logic [2:0] KIND_HIT    = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

endpackage

// ===== hdl/window_stack_hit_test_top.sv =====
// ----------------------------------------------------------------------------
// window_stack_hit_test_top
// Bottom-to-top window stack in one slot memory, with add, remove, raise,
// move and hit test requests.
// ----------------------------------------------------------------------------
// A request walks the slot memory one entry per cycle (search pass, then a shift
// pass for remove and raise); a hit test searches from the top entry down.
// Handshake: one request at a time; the next is accepted the cycle after the
// result is taken.
// Reset: synchronous, active low; clears count, FSM, result valid and loads
// default registers. Slot memory is not cleared (read only below count).
module window_stack_hit_test_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [11:0]                 i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [2:0]                  i_kind,
    input  logic [7:0]                  i_window_handle,
    input  logic [wsht_pkg::COORD_BITS-1:0] i_pos_x,
    input  logic [wsht_pkg::COORD_BITS-1:0] i_pos_y,
    input  logic [wsht_pkg::COORD_BITS-1:0] i_width,
    input  logic [wsht_pkg::COORD_BITS-1:0] i_height,
    input  logic signed [8:0]           i_delta_x,
    input  logic signed [8:0]           i_delta_y,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_status,
    output logic                        o_hit,
    output logic [7:0]                  o_hit_handle,
    output logic                        o_on_close_button,
    output logic                        o_on_title,
    output logic [4:0]                  o_window_count,
    output logic [wsht_pkg::COORD_BITS-1:0] o_moved_x,
    output logic [wsht_pkg::COORD_BITS-1:0] o_moved_y
);
    import wsht_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DEC   = 6'b000100,
        S_SHIFT = 6'b001000,
        S_WRTOP = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    localparam int SW = COORD_BITS + 3; // signed work width

    t_state r_state, n_state;
    t_coord r_scr_w, r_scr_h;
    logic [7:0] r_title_h, r_close_w;
    logic [CNT_BITS-1:0] r_count;

    // request
    logic [2:0] r_kind;
    t_handle r_h;
    t_coord r_px, r_py, r_w, r_ht;
    logic signed [8:0] r_dx, r_dy;

    // memory
    t_slot mem [MAX_WINDOWS];
    t_slot r_rd;
    logic [IDX_BITS-1:0] r_raddr;
    logic r_rd_ok;                  // r_rd holds entry r_cur
    logic [CNT_BITS-1:0] r_cur;     // entry index being examined
    logic [CNT_BITS-1:0] r_idx;
    logic r_found;
    t_slot r_saved;
    logic [IDX_BITS-1:0] r_wr_idx;

    logic w_we;
    logic [IDX_BITS-1:0] w_waddr;
    t_slot w_wdata;

    // outputs
    logic r_ovalid;
    logic [1:0] r_st;
    logic r_hit, r_onc, r_ont;
    t_handle r_hh;
    t_coord r_mx, r_my;

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rd <= mem[r_raddr];
    end

    // hit evaluation on read entry
    logic signed [SW-1:0] x0, y0, x1, y1, cx0, cx1, ty1, spx, spy;
    logic w_in, w_inc, w_inty;
    assign x0  = SW'(r_rd.left);
    assign y0  = SW'(r_rd.top);
    assign x1  = x0 + SW'(r_rd.width);
    assign y1  = y0 + SW'(r_rd.height);
    assign cx0 = x1 - SW'(CLOSE_OFFSET);
    assign cx1 = cx0 + SW'(r_close_w);
    assign ty1 = y0 + SW'(r_title_h);
    assign spx = SW'(r_px);
    assign spy = SW'(r_py);
    assign w_in   = spx > x0 && spx < x1 && spy > y0 && spy < y1;
    assign w_inty = spy > y0 && spy < ty1;
    assign w_inc  = spx > cx0 && spx < cx1 && w_inty;

    // clamp for move, on the entry captured at the match
    logic signed [SW-1:0] vx, vy, hx, hy, cxv, cyv;
    assign vx = SW'(r_saved.left) + SW'(r_dx);
    assign vy = SW'(r_saved.top) + SW'(r_dy);
    assign hx = SW'(r_scr_w) - SW'(r_saved.width);
    assign hy = SW'(r_scr_h) - SW'(r_saved.height);
    always_comb begin
        cxv = (vx > hx) ? hx : vx;
        if (cxv < 0) cxv = '0;
        cyv = (vy > hy) ? hy : vy;
        if (cyv < 0) cyv = '0;
    end

    wire w_top_scan = (r_kind == KIND_HIT);

    always_comb begin
        n_state = r_state;
        w_we = 1'b0;
        w_waddr = r_wr_idx;
        w_wdata = r_rd;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_SCAN;
            S_SCAN: begin
                if (r_rd_ok) begin
                    if (w_top_scan ? w_in : (r_rd.handle == r_h)) n_state = S_DEC;
                    else if (r_cur == (w_top_scan ? CNT_BITS'(0) : r_count - 1'b1))
                        n_state = S_DEC;
                end else if (r_count == '0) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_OUT;
                if (r_kind == KIND_ADD && !r_found && r_count < CNT_BITS'(MAX_WINDOWS)) begin
                    w_we = 1'b1;
                    w_waddr = r_count[IDX_BITS-1:0];
                    w_wdata = '{r_h, r_px, r_py, r_w, r_ht};
                end else if (r_kind == KIND_MOVE && r_found) begin
                    w_we = 1'b1;
                    w_waddr = r_idx[IDX_BITS-1:0];
                    w_wdata = r_saved;
                    w_wdata.left = cxv[COORD_BITS-1:0];
                    w_wdata.top  = cyv[COORD_BITS-1:0];
                end else if ((r_kind == KIND_REMOVE || r_kind == KIND_RAISE) && r_found) begin
                    n_state = (r_idx + 1'b1 < r_count) ? S_SHIFT :
                              (r_kind == KIND_RAISE ? S_WRTOP : S_OUT);
                end
            end
            S_SHIFT: begin
                // r_rd holds entry r_cur = r_wr_idx+1
                if (r_rd_ok) begin
                    w_we = 1'b1;
                    w_wdata = r_rd;
                    if (r_cur + 1'b1 >= r_count)
                        n_state = (r_kind == KIND_RAISE) ? S_WRTOP : S_OUT;
                end
            end
            S_WRTOP: begin
                w_we = 1'b1;
                w_waddr = IDX_BITS'(r_count - 1'b1);
                w_wdata = r_saved;
                n_state = S_OUT;
            end
            // hold until the result is taken
            S_OUT: if (r_ovalid && i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovalid <= 1'b0;
            r_scr_w <= COORD_BITS'(1024);
            r_scr_h <= COORD_BITS'(768);
            r_title_h <= 8'd20;
            r_close_w <= 8'd16;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SCREEN_W: r_scr_w <= i_cfg_data[COORD_BITS-1:0];
                    REG_SCREEN_H: r_scr_h <= i_cfg_data[COORD_BITS-1:0];
                    REG_TITLE_H:  r_title_h <= i_cfg_data[7:0];
                    REG_CLOSE_W:  r_close_w <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    r_rd_ok <= 1'b0;
                    if (i_valid) begin
                        r_kind <= i_kind; r_h <= i_window_handle;
                        r_px <= i_pos_x; r_py <= i_pos_y;
                        r_w <= i_width; r_ht <= i_height;
                        r_dx <= i_delta_x; r_dy <= i_delta_y;
                        r_found <= 1'b0;
                        r_hit <= 1'b0; r_onc <= 1'b0; r_ont <= 1'b0; r_hh <= '0;
                        r_mx <= '0; r_my <= '0;
                        if (i_kind == KIND_HIT) begin
                            r_cur <= r_count - 1'b1;
                            r_raddr <= IDX_BITS'(r_count - 1'b1);
                        end else begin
                            r_cur <= '0;
                            r_raddr <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_rd_ok) begin
                        if (w_top_scan ? w_in : (r_rd.handle == r_h)) begin
                            r_found <= 1'b1;
                            r_idx <= r_cur;
                            r_saved <= r_rd;
                            r_hit <= w_top_scan;
                            r_hh <= w_top_scan ? r_rd.handle : '0;
                            r_onc <= w_top_scan && w_inc;
                            r_ont <= w_top_scan && !w_inc && w_inty;
                            r_rd_ok <= 1'b0;
                        end else begin
                            r_cur <= w_top_scan ? r_cur - 1'b1 : r_cur + 1'b1;
                            r_raddr <= w_top_scan ? IDX_BITS'(r_cur - 2'd2)
                                                  : IDX_BITS'(r_cur + 2'd2);
                        end
                    end else begin
                        r_rd_ok <= (r_count != '0);
                        r_raddr <= w_top_scan ? IDX_BITS'(r_cur - 1'b1)
                                              : IDX_BITS'(r_cur + 1'b1);
                    end
                end
                S_DEC: begin
                    r_rd_ok <= 1'b0;
                    r_wr_idx <= r_idx[IDX_BITS-1:0];
                    r_cur <= r_idx + 1'b1;
                    r_raddr <= IDX_BITS'(r_idx + 1'b1);
                    case (r_kind)
                        KIND_ADD: begin
                            if (r_found) r_st <= ST_PRESENT;
                            else if (r_count >= CNT_BITS'(MAX_WINDOWS)) r_st <= ST_FULL;
                            else begin
                                r_st <= ST_DONE;
                                r_count <= r_count + 1'b1;
                            end
                        end
                        KIND_REMOVE, KIND_RAISE, KIND_MOVE: begin
                            if (!r_found) r_st <= ST_MISSING;
                            else begin
                                r_st <= ST_DONE;
                                if (r_kind == KIND_MOVE) begin
                                    r_mx <= cxv[COORD_BITS-1:0];
                                    r_my <= cyv[COORD_BITS-1:0];
                                end
                            end
                        end
                        default: r_st <= ST_DONE;
                    endcase
                end
                S_SHIFT: begin
                    r_rd_ok <= 1'b1;
                    r_raddr <= r_rd_ok ? IDX_BITS'(r_cur + 2'd2) : IDX_BITS'(r_cur + 1'b1);
                    if (r_rd_ok) begin
                        r_wr_idx <= r_wr_idx + 1'b1;
                        r_cur <= r_cur + 1'b1;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        if (r_kind == KIND_REMOVE && r_found) r_count <= r_count - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Move clamps from r_saved, the copy of the matched entry taken in S_SCAN;
    // r_rd has already moved on to the next address by S_DEC.

    assign o_valid = r_ovalid;
    assign o_status = r_st;
    assign o_hit = r_hit;
    assign o_hit_handle = r_hh;
    assign o_on_close_button = r_onc;
    assign o_on_title = r_ont;
    assign o_window_count = 5'(r_count);
    assign o_moved_x = r_mx;
    assign o_moved_y = r_my;

    ap_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(MAX_WINDOWS)) else $error("count over depth");
    ap_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accept while result pending");
    ap_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> !o_on_close_button && !o_on_title)
        else $error("zone flag without hit");
endmodule

// ===== test/window_stack_hit_test_top_test.sv =====
// ----------------------------------------------------------------------------
// window_stack_hit_test_top_test: regression bench for the window stack
// Directed table of requests, then random window traffic under several
// idling phases; every result is checked against a behavioral predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module window_stack_hit_test_top_test;
    import wsht_pkg::*;

    localparam int N_RANDOM = 1200;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  handle;
        logic [11:0] px;
        logic [11:0] py;
        logic [11:0] w;
        logic [11:0] h;
        logic [8:0]  dx;
        logic [8:0]  dy;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [7:0]  hit_handle;
        logic        on_close;
        logic        on_title;
        logic [4:0]  count;
        logic [11:0] mx;
        logic [11:0] my;
    } t_rsp;

    typedef struct {
        t_req req;
        bit   has_fixed;
        t_rsp fixed;
    } t_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = '0;
    logic [11:0] i_cfg_data = '0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [2:0]  i_kind = '0;
    logic [7:0]  i_window_handle = '0;
    logic [11:0] i_pos_x = '0, i_pos_y = '0, i_width = '0, i_height = '0;
    logic signed [8:0] i_delta_x = '0, i_delta_y = '0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [1:0]  o_status;
    logic        o_hit, o_on_close_button, o_on_title;
    logic [7:0]  o_hit_handle;
    logic [4:0]  o_window_count;
    logic [11:0] o_moved_x, o_moved_y;

    window_stack_hit_test_top i_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    t_slot       stack_mdl[MAX_WINDOWS];
    int          depth_mdl;
    int          scr_w, scr_h, title_h, close_w;
    t_rsp        pending_rsp[$];
    int          errors = 0;
    int          cycles = 0;
    int          send_idle_pct = 0, recv_stall_pct = 0;
    bit          hold_off = 0;

    function automatic int find_handle(logic [7:0] hd);
        for (int i = 0; i < depth_mdl; i++)
            if (stack_mdl[i].handle == hd) return i;
        return -1;
    endfunction

    function automatic int clamp_edge(int pos, int d, int scr, int sz);
        int v, hi;
        v = pos + d;
        hi = scr - sz;
        if (v > hi) v = hi;
        if (v < 0) v = 0;
        return v & 12'hFFF;
    endfunction

    function automatic t_rsp window_op(t_req r);
        t_rsp o;
        int idx, x0, y0, x1, y1, cx0, cx1, ty1, px, py;
        t_slot s;
        o = '0;
        idx = find_handle(r.handle);
        px = r.px;
        py = r.py;
        case (r.kind)
            KIND_ADD: begin
                if (idx >= 0) o.status = ST_PRESENT;
                else if (depth_mdl >= MAX_WINDOWS) o.status = ST_FULL;
                else begin
                    stack_mdl[depth_mdl] = '{r.handle, r.px, r.py, r.w, r.h};
                    depth_mdl++;
                end
            end
            KIND_REMOVE, KIND_RAISE: begin
                if (idx < 0) o.status = ST_MISSING;
                else begin
                    s = stack_mdl[idx];
                    for (int i = idx; i + 1 < depth_mdl; i++) stack_mdl[i] = stack_mdl[i+1];
                    if (r.kind == KIND_REMOVE) depth_mdl--;
                    else stack_mdl[depth_mdl-1] = s;
                end
            end
            KIND_MOVE: begin
                if (idx < 0) o.status = ST_MISSING;
                else begin
                    stack_mdl[idx].left = 12'(clamp_edge(stack_mdl[idx].left,
                        $signed(r.dx), scr_w, stack_mdl[idx].width));
                    stack_mdl[idx].top = 12'(clamp_edge(stack_mdl[idx].top,
                        $signed(r.dy), scr_h, stack_mdl[idx].height));
                    o.mx = stack_mdl[idx].left;
                    o.my = stack_mdl[idx].top;
                end
            end
            KIND_HIT: begin
                for (int k = depth_mdl - 1; k >= 0; k--) begin
                    x0 = stack_mdl[k].left;
                    y0 = stack_mdl[k].top;
                    x1 = x0 + stack_mdl[k].width;
                    y1 = y0 + stack_mdl[k].height;
                    if (!(px > x0 && px < x1 && py > y0 && py < y1)) continue;
                    o.hit = 1'b1;
                    o.hit_handle = stack_mdl[k].handle;
                    cx0 = x1 - CLOSE_OFFSET;
                    cx1 = cx0 + close_w;
                    ty1 = y0 + title_h;
                    if (px > cx0 && px < cx1 && py > y0 && py < ty1) o.on_close = 1'b1;
                    else if (py > y0 && py < ty1) o.on_title = 1'b1;
                    break;
                end
            end
            default: ;
        endcase
        o.count = 5'(depth_mdl);
        return o;
    endfunction

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(logic [1:0] idx, int val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 12'(val);
        @(posedge i_clk);
        case (idx)
            REG_SCREEN_W: scr_w = val;
            REG_SCREEN_H: scr_h = val;
            REG_TITLE_H:  title_h = val;
            default:      close_w = val;
        endcase
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (2 * MAX_WINDOWS + 8) @(posedge i_clk);
    endtask

    task automatic send_req(t_req r, bit has_fixed = 0, t_rsp fixed = '0);
        t_rsp e;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_kind, i_window_handle, i_pos_x, i_pos_y, i_width, i_height,
         i_delta_x, i_delta_y} <= r;
        do @(posedge i_clk); while (!o_ready);
        e = window_op(r);
        if (has_fixed && e != fixed) begin
            $error("directed row disagrees with predictor: %h vs %h", fixed, e);
            errors++;
        end
        pending_rsp.push_back(has_fixed ? fixed : e);
    endtask

    // receiver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_rsp.size() == 0) begin
                    $error("unexpected result");
                    errors++;
                end else begin
                    t_rsp e;
                    e = pending_rsp.pop_front();
                    if (o_status != e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status); errors++; end
                    if (o_hit != e.hit) begin
                        $error("hit exp %0d got %0d", e.hit, o_hit); errors++; end
                    if (o_hit_handle != e.hit_handle) begin
                        $error("hit_handle exp %0d got %0d", e.hit_handle, o_hit_handle);
                        errors++;
                    end
                    if (o_on_close_button != e.on_close) begin
                        $error("on_close_button exp %0d got %0d", e.on_close,
                               o_on_close_button);
                        errors++;
                    end
                    if (o_on_title != e.on_title) begin
                        $error("on_title exp %0d got %0d", e.on_title, o_on_title); errors++; end
                    if (o_window_count != e.count) begin
                        $error("window_count exp %0d got %0d", e.count, o_window_count);
                        errors++;
                    end
                    if (o_moved_x != e.mx) begin
                        $error("moved_x exp %0d got %0d", e.mx, o_moved_x); errors++; end
                    if (o_moved_y != e.my) begin
                        $error("moved_y exp %0d got %0d", e.my, o_moved_y); errors++; end
                end
            end
            i_ready <= !hold_off && !(recv_stall_pct != 0 &&
                                      $urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_req rand_req(int hpool);
        t_req r;
        int sel;
        r.kind = 3'($urandom_range(4));
        sel = $urandom_range(99);
        if (sel < 3) r.kind = 3'($urandom_range(7, 5));
        r.handle = (sel < 10) ? 8'($urandom_range(255)) : 8'($urandom_range(hpool - 1));
        r.w = ($urandom_range(9) == 0) ? 12'($urandom_range(4095))
                                       : 12'($urandom_range(400, 1));
        r.h = ($urandom_range(9) == 0) ? 12'($urandom_range(4095))
                                       : 12'($urandom_range(300, 1));
        r.px = ($urandom_range(9) == 0) ? 12'($urandom_range(4095))
                                        : 12'($urandom_range(1100));
        r.py = ($urandom_range(9) == 0) ? 12'($urandom_range(4095))
                                        : 12'($urandom_range(800));
        if (r.kind == KIND_HIT && depth_mdl > 0 && $urandom_range(1)) begin
            int k;
            k = $urandom_range(depth_mdl - 1);
            r.px = 12'(stack_mdl[k].left + $urandom_range(stack_mdl[k].width));
            r.py = 12'(stack_mdl[k].top + $urandom_range(30));
        end
        r.dx = 9'($urandom);
        r.dy = 9'($urandom);
        return r;
    endfunction

    t_row dir_rows[$];

    initial begin
        t_req r;
        int phase;
        scr_w = 1024; scr_h = 768; title_h = 20; close_w = 16;
        depth_mdl = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: kind, handle, x, y, w, h, dx, dy
        dir_rows.push_back('{'{KIND_HIT, 8'd0, 12'd5, 12'd5, 12'd1, 12'd1, 9'd0, 9'd0},
                             1, '{ST_DONE, 0, 0, 0, 0, 5'd0, 0, 0}});
        dir_rows.push_back('{'{KIND_REMOVE, 8'd9, 12'd0, 12'd0, 12'd1, 12'd1, 9'd0, 9'd0},
                             1, '{ST_MISSING, 0, 0, 0, 0, 5'd0, 0, 0}});
        dir_rows.push_back('{'{KIND_ADD, 8'd255, 12'd100, 12'd100, 12'd200, 12'd100, 0, 0},
                             1, '{ST_DONE, 0, 0, 0, 0, 5'd1, 0, 0}});
        dir_rows.push_back('{'{KIND_ADD, 8'd255, 12'd0, 12'd0, 12'd5, 12'd5, 0, 0},
                             1, '{ST_PRESENT, 0, 0, 0, 0, 5'd1, 0, 0}});
        dir_rows.push_back('{'{KIND_ADD, 8'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 0, 0},
                             0, '0});
        dir_rows.push_back('{'{KIND_ADD, 8'd7, 12'd0, 12'd0, 12'd10, 12'd10, 0, 0}, 0, '0});
        dir_rows.push_back('{'{KIND_HIT, 8'd0, 12'd290, 12'd110, 1, 1, 0, 0}, 0, '0});
        dir_rows.push_back('{'{KIND_HIT, 8'd0, 12'd200, 12'd110, 1, 1, 0, 0}, 0, '0});
        dir_rows.push_back('{'{KIND_HIT, 8'd0, 12'd200, 12'd150, 1, 1, 0, 0}, 0, '0});
        dir_rows.push_back('{'{KIND_HIT, 8'd0, 12'd5, 12'd5, 1, 1, 0, 0}, 0, '0});
        dir_rows.push_back('{'{KIND_HIT, 8'd0, 12'd100, 12'd150, 1, 1, 0, 0}, 0, '0});
        dir_rows.push_back('{'{KIND_RAISE, 8'd7, 0, 0, 1, 1, 0, 0}, 0, '0});
        dir_rows.push_back('{'{KIND_RAISE, 8'd255, 0, 0, 1, 1, 0, 0}, 0, '0});
        dir_rows.push_back('{'{KIND_RAISE, 8'd42, 0, 0, 1, 1, 0, 0}, 0, '0});
        dir_rows.push_back('{'{KIND_MOVE, 8'd255, 0, 0, 1, 1, 9'h0FF, 9'h100}, 0, '0});
        dir_rows.push_back('{'{KIND_MOVE, 8'd255, 0, 0, 1, 1, 9'h100, 9'h0FF}, 0, '0});
        // wider than screen: clamps to zero
        dir_rows.push_back('{'{KIND_MOVE, 8'd0, 0, 0, 1, 1, 9'h0FF, 9'h0FF}, 0, '0});
        dir_rows.push_back('{'{KIND_MOVE, 8'd77, 0, 0, 1, 1, 9'd3, 9'd3}, 0, '0});
        dir_rows.push_back('{'{KIND_ADD, 8'd8, 12'd5, 12'd5, 12'd10, 12'd0, 0, 0}, 0, '0});
        // close zone left bound negative near left border
        dir_rows.push_back('{'{KIND_HIT, 8'd0, 12'd1, 12'd1, 1, 1, 0, 0}, 0, '0});
        dir_rows.push_back('{'{3'd5, 8'd1, 0, 0, 1, 1, 0, 0}, 0, '0});
        dir_rows.push_back('{'{3'd7, 8'd1, 0, 0, 1, 1, 0, 0}, 0, '0});
        dir_rows.push_back('{'{KIND_REMOVE, 8'd255, 0, 0, 1, 1, 0, 0}, 0, '0});
        for (int i = 0; i < 14; i++)
            dir_rows.push_back('{'{KIND_ADD, 8'(100 + i), 12'(i * 30), 12'(i * 20),
                                   12'd90, 12'd80, 0, 0}, 0, '0});
        dir_rows.push_back('{'{KIND_ADD, 8'd200, 0, 0, 5, 5, 0, 0},
                             1, '{ST_FULL, 0, 0, 0, 0, 5'd16, 0, 0}});
        foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].has_fixed,
                                       dir_rows[i].fixed);
        drain();

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                3: begin send_idle_pct = 11; recv_stall_pct = 11; end
                default: begin send_idle_pct = $urandom_range(30); recv_stall_pct = 20; end
            endcase
            drain();
            case (phase)
                0: begin write_reg(REG_SCREEN_W, 1); write_reg(REG_SCREEN_H, 1);
                         write_reg(REG_TITLE_H, 1); write_reg(REG_CLOSE_W, 1); end
                1: begin write_reg(REG_SCREEN_W, 4095); write_reg(REG_SCREEN_H, 4095);
                         write_reg(REG_TITLE_H, 255); write_reg(REG_CLOSE_W, 255); end
                2: begin write_reg(REG_SCREEN_W, 1024); write_reg(REG_SCREEN_H, 768);
                         write_reg(REG_TITLE_H, 20); write_reg(REG_CLOSE_W, 16); end
                default: begin
                    write_reg(REG_SCREEN_W, $urandom_range(4095, 1));
                    write_reg(REG_SCREEN_H, $urandom_range(4095, 1));
                    write_reg(REG_TITLE_H, $urandom_range(255, 1));
                    write_reg(REG_CLOSE_W, $urandom_range(255, 1));
                end
            endcase
            i_cfg_we <= 1'b0;
            if (phase == 4) begin
                // long receiver hold-off; sender keeps pushing
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                r = rand_req(phase[0] ? 24 : 40);
                send_req(r);
            end
        end
        drain();
        if (errors == 0 && pending_rsp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/wsht_pkg.sv
hdl/window_stack_hit_test_top.sv
test/window_stack_hit_test_top_test.sv
